/* sv/lsqfq_pkg.sv */
// Shared types and constants for the LSQ fake-quantizer gradient block.
`default_nettype none

package lsqfq_pkg;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SCALE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_STEP_SCALE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_MIN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_MAX      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAD_GAIN      = 3'd4;

   typedef struct packed {
      logic [31:0]        step_scale;
      logic [31:0]        inv_step_scale;
      logic signed [15:0] level_min;
      logic [14:0]        level_max;
      logic [31:0]        grad_gain;
   } cfg_type;

   // operand pair routed to the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE   = 3'd0,
      MUL_XS     = 3'd1,
      MUL_LEVEL  = 3'd2,
      MUL_GRAD   = 3'd3,
      MUL_MAG_HI = 3'd4,
      MUL_MAG_LO = 3'd5
   } mul_sel_type;

   typedef struct packed {
      logic        load_item;
      mul_sel_type mul_sel;
      logic        load_prod;
      logic        load_round;
      logic        load_clamp;
      logic        load_quant;
      logic        load_contrib;
      logic        load_accum;
      logic        load_mag;
      logic        load_hi;
      logic        load_psum;
      logic        load_sat;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* sv/lsqfq_csr.sv */
// Configuration register file written through the csr word channel.
`default_nettype none

module lsqfq_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lsqfq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                          csr_wdata,
   output lsqfq_pkg::cfg_type                   cfg
);
   import lsqfq_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEP_SCALE:     cfg_in.step_scale     = csr_wdata;
            CSR_INV_STEP_SCALE: cfg_in.inv_step_scale = csr_wdata;
            CSR_LEVEL_MIN:      cfg_in.level_min      = csr_wdata[15:0];
            CSR_LEVEL_MAX:      cfg_in.level_max      = csr_wdata[14:0];
            CSR_GRAD_GAIN:      cfg_in.grad_gain      = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_scale     <= 32'h0001_0000;
         cfg_ff.inv_step_scale <= 32'h0001_0000;
         cfg_ff.level_min      <= -16'sd128;
         cfg_ff.level_max      <= 15'd127;
         cfg_ff.grad_gain      <= 32'h0001_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* sv/lsqfq_ctrl.sv */
// Sequencing state machine: steps one element through the shared datapath.
`default_nettype none

module lsqfq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lsqfq_pkg::dp_status_type status,
   output lsqfq_pkg::dp_cmd_type    cmd
);
   import lsqfq_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_SCALE    = 14'b00000000000010,
      ST_ROUND    = 14'b00000000000100,
      ST_CLAMP    = 14'b00000000001000,
      ST_MUL_Q    = 14'b00000000010000,
      ST_MUL_G    = 14'b00000000100000,
      ST_CONTRIB  = 14'b00000001000000,
      ST_ACCUM    = 14'b00000010000000,
      ST_ABS      = 14'b00000100000000,
      ST_MUL_HI   = 14'b00001000000000,
      ST_MUL_LO   = 14'b00010000000000,
      ST_FINISH   = 14'b00100000000000,
      ST_SATURATE = 14'b01000000000000,
      ST_EMIT     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.mul_sel   = MUL_XS;
            cmd.load_prod = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.load_round = 1'b1;
            state_in       = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.load_clamp = 1'b1;
            state_in       = ST_MUL_Q;
         end
         ST_MUL_Q: begin
            cmd.mul_sel   = MUL_LEVEL;
            cmd.load_prod = 1'b1;
            state_in      = ST_MUL_G;
         end
         ST_MUL_G: begin
            cmd.load_quant = 1'b1;
            cmd.mul_sel    = MUL_GRAD;
            cmd.load_prod  = 1'b1;
            state_in       = ST_CONTRIB;
         end
         ST_CONTRIB: begin
            cmd.load_contrib = 1'b1;
            state_in         = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.load_accum = 1'b1;
            state_in       = status.last ? ST_ABS : ST_EMIT;
         end
         ST_ABS: begin
            cmd.load_mag = 1'b1;
            state_in     = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_sel   = MUL_MAG_HI;
            cmd.load_prod = 1'b1;
            state_in      = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.load_hi   = 1'b1;
            cmd.mul_sel   = MUL_MAG_LO;
            cmd.load_prod = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.load_psum = 1'b1;
            state_in      = ST_SATURATE;
         end
         ST_SATURATE: begin
            cmd.load_sat = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/lsqfq_dp.sv */
// Datapath: shared 33x33 multiplier, rounding, clamping, accumulator, result word.
`default_nettype none

module lsqfq_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [31:0]       req_sample_value,
   input  logic signed [31:0]       req_upstream_grad,
   input  logic                     req_final_element,
   input  lsqfq_pkg::cfg_type       cfg,
   input  lsqfq_pkg::dp_cmd_type    cmd,
   output lsqfq_pkg::dp_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_quantized_value,
   output logic signed [31:0]       rsp_input_grad,
   output logic signed [47:0]       rsp_scale_grad,
   output logic                     rsp_scale_grad_valid
);
   import lsqfq_pkg::*;

   localparam logic signed [64:0] SAT32_HI = 65'sd2147483647;
   localparam logic signed [64:0] SAT32_LO = -65'sd2147483648;
   localparam logic [63:0]        SG_POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0]        SG_NEG_LIM = 64'h0000_8000_0000_0000;

   // element
   logic signed [31:0] x_ff, g_ff;
   logic               last_ff;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic signed [64:0] prod_ff;

   // rounding / classification
   logic signed [63:0] xs;
   logic signed [64:0] xs_ext, xs_bias, xs_rnd;
   logic signed [63:0] lo_bound, hi_bound;
   logic signed [32:0] r_ff, r_in;
   logic               below_ff, below_in, above_ff, above_in;
   logic [32:0]        xs_lo_ff;

   // clamp
   logic signed [32:0] lmin33, lmax33, t33, op_ff, op_in;
   logic [32:0]        d33;
   logic signed [16:0] lvl_ff, lvl_in;
   logic               inside_ff;

   // quantized value
   logic signed [31:0] q_ff, q_in;

   // scale gradient term and accumulator
   logic signed [64:0] c_bias, c_rnd, acc_sum;
   logic signed [63:0] contrib_ff, contrib_in;
   logic signed [63:0] sum_ff, sum_in, acc_sat;

   // final scaling by grad_gain
   logic               neg_ff;
   logic [63:0]        mag_ff, hi_ff, psum_ff, psum_in;
   logic [47:0]        neg_p;
   logic signed [47:0] sg_ff, sg_in;

   // result word
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_q_ff, out_ig_ff;
   logic signed [47:0] out_sg_ff;
   logic               out_sgv_ff;

   assign status.last     = last_ff;
   assign status.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid            = out_valid_ff;
   assign rsp_quantized_value  = out_q_ff;
   assign rsp_input_grad       = out_ig_ff;
   assign rsp_scale_grad       = out_sg_ff;
   assign rsp_scale_grad_valid = out_sgv_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_XS: begin
            mul_a = {x_ff[31], x_ff};
            mul_b = {1'b0, cfg.inv_step_scale};
         end
         MUL_LEVEL: begin
            mul_a = {{16{lvl_ff[16]}}, lvl_ff};
            mul_b = {1'b0, cfg.step_scale};
         end
         MUL_GRAD: begin
            mul_a = {g_ff[31], g_ff};
            mul_b = op_ff;
         end
         MUL_MAG_HI: begin
            mul_a = {1'b0, mag_ff[63:32]};
            mul_b = {1'b0, cfg.grad_gain};
         end
         MUL_MAG_LO: begin
            mul_a = {1'b0, mag_ff[31:0]};
            mul_b = {1'b0, cfg.grad_gain};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // xs in Q32.32, rounded half away from zero to an integer level
   always_comb begin
      xs       = prod_ff[63:0];
      xs_ext   = {xs[63], xs};
      xs_bias  = xs[63] ? 65'sh0_7FFF_FFFF : 65'sh0_8000_0000;
      xs_rnd   = xs_ext + xs_bias;
      r_in     = xs_rnd[64:32];
      lo_bound = {{16{cfg.level_min[15]}}, cfg.level_min, 32'h0};
      hi_bound = {17'h0, cfg.level_max, 32'h0};
      below_in = xs < lo_bound;
      above_in = xs > hi_bound;
   end

   always_comb begin
      lmin33 = {{17{cfg.level_min[15]}}, cfg.level_min};
      lmax33 = {18'h0, cfg.level_max};
      t33    = (r_ff < lmin33) ? lmin33 : r_ff;
      lvl_in = (t33 > lmax33) ? lmax33[16:0] : t33[16:0];
      // round(xs) - xs fits in 33 bits, so the low bits suffice
      d33    = {r_ff[0], 32'h0} - xs_lo_ff;
      if (below_ff) begin
         op_in = lmin33;
      end else if (above_ff) begin
         op_in = lmax33;
      end else begin
         op_in = d33;
      end
   end

   always_comb begin
      if (prod_ff > SAT32_HI) begin
         q_in = 32'sh7FFF_FFFF;
      end else if (prod_ff < SAT32_LO) begin
         q_in = -32'sh8000_0000;
      end else begin
         q_in = prod_ff[31:0];
      end
   end

   always_comb begin
      c_bias = prod_ff[64] ? 65'sh7FFF : 65'sh8000;
      c_rnd  = prod_ff + c_bias;
      if (inside_ff) begin
         contrib_in = {{15{c_rnd[64]}}, c_rnd[64:16]};
      end else begin
         contrib_in = {prod_ff[47:0], 16'h0};
      end
   end

   always_comb begin
      acc_sum = {sum_ff[63], sum_ff} + {contrib_ff[63], contrib_ff};
      if (acc_sum[64] != acc_sum[63]) begin
         acc_sat = acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
         acc_sat = acc_sum[63:0];
      end
      sum_in = sum_ff;
      if (cmd.load_accum) begin
         sum_in = acc_sat;
      end else if (cmd.load_mag) begin
         sum_in = '0;
      end
   end

   always_comb begin
      psum_in = hi_ff + {32'h0, prod_ff[63:32]} + {63'h0, prod_ff[31]};
      neg_p   = 48'h0 - psum_ff[47:0];
      if (neg_ff) begin
         sg_in = (psum_ff > SG_NEG_LIM) ? 48'sh8000_0000_0000 : neg_p;
      end else begin
         sg_in = (psum_ff > SG_POS_LIM) ? 48'sh7FFF_FFFF_FFFF : psum_ff[47:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         x_ff    <= req_sample_value;
         g_ff    <= req_upstream_grad;
         last_ff <= req_final_element;
      end
      if (cmd.load_prod) begin
         prod_ff <= mul_full[64:0];
      end
      if (cmd.load_round) begin
         r_ff     <= r_in;
         below_ff <= below_in;
         above_ff <= above_in;
         xs_lo_ff <= prod_ff[32:0];
      end
      if (cmd.load_clamp) begin
         lvl_ff    <= lvl_in;
         op_ff     <= op_in;
         inside_ff <= !below_ff && !above_ff;
      end
      if (cmd.load_quant) begin
         q_ff <= q_in;
      end
      if (cmd.load_contrib) begin
         contrib_ff <= contrib_in;
      end
      if (cmd.load_mag) begin
         neg_ff <= sum_ff[63];
         mag_ff <= sum_ff[63] ? 64'h0 - sum_ff : sum_ff;
      end
      if (cmd.load_hi) begin
         hi_ff <= prod_ff[63:0];
      end
      if (cmd.load_psum) begin
         psum_ff <= psum_in;
      end
      if (cmd.load_sat) begin
         sg_ff <= sg_in;
      end
      if (cmd.load_out) begin
         out_q_ff   <= q_ff;
         out_ig_ff  <= inside_ff ? g_ff : 32'sh0;
         out_sg_ff  <= last_ff ? sg_ff : 48'sh0;
         out_sgv_ff <= last_ff;
      end
   end

endmodule

`default_nettype wire

/* sv/lsq_fake_quant_grad.sv */
// Top level: LSQ fake quantizer with straight-through and step-size gradients.
// Each element is stepped through the one shared 33x33 multiplier, used three times per
// element and twice more on a final element, with a register after every product; a new
// element is accepted only after the previous result has been loaded into the result word.
// Reset restores the registers to their defaults and clears the gradient sum.
`default_nettype none

module lsq_fake_quant_grad (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_sample_value,
   input  logic signed [31:0]                req_upstream_grad,
   input  logic                              req_final_element,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_quantized_value,
   output logic signed [31:0]                rsp_input_grad,
   output logic signed [47:0]                rsp_scale_grad,
   output logic                              rsp_scale_grad_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsqfq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                       csr_wdata
);
   import lsqfq_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   lsqfq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsqfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lsqfq_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_sample_value     (req_sample_value),
      .req_upstream_grad    (req_upstream_grad),
      .req_final_element    (req_final_element),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_quantized_value  (rsp_quantized_value),
      .rsp_input_grad       (rsp_input_grad),
      .rsp_scale_grad       (rsp_scale_grad),
      .rsp_scale_grad_valid (rsp_scale_grad_valid)
   );

endmodule

`default_nettype wire

/* bench/lsq_fake_quant_grad_test.sv */
// Testbench for lsq_fake_quant_grad: streams tensors, predicts each word and checks every result.
`timescale 1ns / 100ps

module lsq_fake_quant_grad_test;
   import lsqfq_pkg::*;

   localparam longint TWO32 = 64'sh1_0000_0000;
   localparam longint unsigned SG_LIMIT = 64'd140737488355327;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] g;
      logic               last;
   } element_type;

   typedef struct {
      logic signed [31:0] quant;
      logic signed [31:0] igrad;
      logic signed [47:0] sgrad;
      logic               sg_valid;
   } element_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_sample_value = '0;
   logic signed [31:0] req_upstream_grad = '0;
   logic req_final_element = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_quantized_value;
   logic signed [31:0] rsp_input_grad;
   logic signed [47:0] rsp_scale_grad;
   logic rsp_scale_grad_valid;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   cfg_type quant_cfg = '{step_scale: 32'h10000, inv_step_scale: 32'h10000,
                          level_min: -16'sd128, level_max: 15'd127, grad_gain: 32'h10000};
   longint scale_sum = 0;

   element_type pending_elements[$];
   element_result_type expected_results[$];
   element_type next_element;
   element_result_type want;

   bit req_took = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int elements_sent = 0;
   int results_seen = 0;
   int sums_seen = 0;
   int tensors_queued = 0;
   int settings_used = 1;

   lsq_fake_quant_grad i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_value(req_sample_value),
      .req_upstream_grad(req_upstream_grad),
      .req_final_element(req_final_element),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_quantized_value(rsp_quantized_value),
      .rsp_input_grad(rsp_input_grad),
      .rsp_scale_grad(rsp_scale_grad),
      .rsp_scale_grad_valid(rsp_scale_grad_valid),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // divide by 2^s, rounding half away from zero
   function automatic longint round_shift(input longint v, input int s);
      longint unsigned mag;
      mag = v;
      if (v < 0) mag = -mag;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic element_result_type quantize_element(input longint x, input longint g,
                                                           input bit last);
      longint xs, r, lo, hi, lvl, prod, contrib, lmin_l, lmax_l, sg;
      logic signed [64:0] acc;
      longint unsigned mag, mh, ml, p, gain_u;
      bit neg;
      element_result_type res;
      lmin_l = longint'($signed(quant_cfg.level_min));
      lmax_l = longint'(quant_cfg.level_max);
      xs = x * longint'(quant_cfg.inv_step_scale);
      r = round_shift(xs, 32);
      lo = lmin_l * TWO32;
      hi = lmax_l * TWO32;
      lvl = r;
      if (lvl < lmin_l) lvl = lmin_l;
      if (lvl > lmax_l) lvl = lmax_l;
      prod = lvl * longint'(quant_cfg.step_scale);
      if (prod > 64'sd2147483647) prod = 64'sd2147483647;
      if (prod < -64'sd2147483648) prod = -64'sd2147483648;
      res.quant = prod[31:0];
      res.igrad = (xs >= lo && xs <= hi) ? g[31:0] : 32'sd0;
      if (xs < lo) contrib = g * lmin_l * 65536;
      else if (xs > hi) contrib = g * lmax_l * 65536;
      else contrib = round_shift(g * (r * TWO32 - xs), 16);
      acc = $signed({scale_sum[63], scale_sum}) + $signed({contrib[63], contrib});
      if (acc[64] != acc[63]) scale_sum = acc[64] ? 64'sh8000_0000_0000_0000
                                                  : 64'sh7FFF_FFFF_FFFF_FFFF;
      else scale_sum = acc[63:0];
      sg = 0;
      if (last) begin
         neg = scale_sum < 0;
         mag = scale_sum;
         if (neg) mag = -mag;
         gain_u = quant_cfg.grad_gain;
         mh = mag >> 32;
         ml = mag & 64'hFFFF_FFFF;
         p = mh * gain_u + ((ml * gain_u + 64'h8000_0000) >> 32);
         if (neg) sg = (p > SG_LIMIT + 1) ? -longint'(SG_LIMIT) - 1 : -longint'(p);
         else sg = (p > SG_LIMIT) ? longint'(SG_LIMIT) : longint'(p);
         scale_sum = 0;
      end
      res.sgrad = sg[47:0];
      res.sg_valid = last;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                       input logic signed [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   // driver: bursts of words with random gaps; a stalled word holds
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_elements.size() != 0) begin
            next_element = pending_elements.pop_front();
            req_valid <= 1'b1;
            req_sample_value <= next_element.x;
            req_upstream_grad <= next_element.g;
            req_final_element <= next_element.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off once armed
   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // monitor: predict on acceptance, check on result, watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
         idle_cycles = 0;
      end else begin
         req_took = req_valid && !req_stall;
         if (req_took) begin
            expected_results.push_back(quantize_element(req_sample_value, req_upstream_grad,
                                                        req_final_element));
            elements_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result word with no element outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (want.sg_valid) sums_seen++;
               check_field("quantized_value", want.quant, rsp_quantized_value);
               check_field("input_grad", want.igrad, rsp_input_grad);
               check_field("scale_grad", want.sgrad, rsp_scale_grad);
               check_field("scale_grad_valid", want.sg_valid, rsp_scale_grad_valid);
            end
         end
         if (req_took || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_STEP_SCALE:     quant_cfg.step_scale = data;
         CSR_INV_STEP_SCALE: quant_cfg.inv_step_scale = data;
         CSR_LEVEL_MIN:      quant_cfg.level_min = data[15:0];
         CSR_LEVEL_MAX:      quant_cfg.level_max = data[14:0];
         CSR_GRAD_GAIN:      quant_cfg.grad_gain = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_quantizer(input logic [31:0] step, input logic [31:0] inv,
                                input logic signed [15:0] lmin, input logic [14:0] lmax,
                                input logic [31:0] gain);
      write_reg(CSR_STEP_SCALE, step);
      write_reg(CSR_INV_STEP_SCALE, inv);
      write_reg(CSR_LEVEL_MIN, {{16{lmin[15]}}, lmin});
      write_reg(CSR_LEVEL_MAX, {17'd0, lmax});
      write_reg(CSR_GRAD_GAIN, gain);
      settings_used++;
   endtask

   task automatic wait_for_drain();
      @(posedge clock);
      while (pending_elements.size() != 0 || expected_results.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   function automatic void add_element(input logic [31:0] x, input logic [31:0] g,
                                       input bit last);
      element_type e;
      e.x = x;
      e.g = g;
      e.last = last;
      pending_elements.push_back(e);
      if (last) tensors_queued++;
   endfunction

   // mostly samples near the level range, some anywhere
   function automatic logic [31:0] make_sample();
      longint lo_t, hi_t, t, step_l, off, v;
      if ($urandom_range(0, 3) == 0) return $urandom;
      lo_t = longint'($signed(quant_cfg.level_min));
      hi_t = longint'(quant_cfg.level_max);
      if (lo_t > hi_t) begin
         t = lo_t;
         lo_t = hi_t;
         hi_t = t;
      end
      lo_t -= 3;
      hi_t += 3;
      t = lo_t + longint'($urandom_range(0, hi_t - lo_t));
      step_l = longint'(quant_cfg.step_scale);
      case ($urandom_range(0, 3))
         0: off = step_l / 2;
         1: off = -(step_l / 2);
         default: off = (step_l == 0) ? 0 : (longint'($urandom) % step_l) - step_l / 2;
      endcase
      v = t * step_l + off;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic logic [31:0] make_grad();
      longint g;
      if ($urandom_range(0, 1) == 0) return $urandom;
      g = longint'($urandom_range(0, 262144)) - 131072;
      return g[31:0];
   endfunction

   function automatic void queue_random_tensors(input int count);
      int n;
      int len;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) add_element(make_sample(), make_grad(), k == len - 1);
         n += len;
      end
   endfunction

   initial begin
      logic [31:0] step;
      logic signed [15:0] lmin;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: rounding halves, range edges, field extremes
      add_element(32'h0000_0000, 32'h0000_0000, 1'b1);
      add_element(32'h0001_8000, 32'h7FFF_FFFF, 1'b0);
      add_element(32'hFFFE_8000, 32'h8000_0000, 1'b0);
      add_element(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_element(32'h8000_0000, 32'h0000_0001, 1'b0);
      add_element(32'h007F_0000, 32'h0001_0000, 1'b0);
      add_element(32'h007F_8000, 32'h0001_0000, 1'b0);
      add_element(32'hFF80_0000, 32'hFFFF_0000, 1'b0);
      add_element(32'hFF7F_8000, 32'h1234_5678, 1'b1);
      wait_for_drain();

      // widest levels and full scale: gradient sum saturates both ways
      set_quantizer(32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd32768, 15'd32767, 32'hFFFF_FFFF);
      for (int k = 0; k < 3; k++) add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, k == 2);
      for (int k = 0; k < 3; k++) add_element(32'h8000_0000, 32'h7FFF_FFFF, k == 2);
      queue_random_tensors(100);
      wait_for_drain();

      // reversed levels: nothing is inside the range
      set_quantizer(32'h0001_0000, 32'h0001_0000, 16'sd5, 15'd2, 32'h0001_0000);
      queue_random_tensors(80);
      wait_for_drain();

      // zero step, reciprocal and gain, collapsed levels
      set_quantizer(32'h0, 32'h0, 16'sd0, 15'd0, 32'h0);
      queue_random_tensors(60);
      wait_for_drain();

      // reciprocal that does not match the step
      set_quantizer(32'h0000_0001, 32'h0003_0000, -16'sd20, 15'd20, 32'h0000_8000);
      queue_random_tensors(80);
      wait_for_drain();

      for (int p = 0; p < 8; p++) begin
         step = $urandom_range(32'h100, 32'h100_0000);
         lmin = ($urandom_range(0, 7) == 0) ? -16'sd32768 : -16'($urandom_range(0, 300));
         set_quantizer(step, 32'(64'h1_0000_0000 / step), lmin, 15'($urandom_range(0, 300)),
                       ($urandom_range(0, 1) == 0) ? $urandom
                                                   : $urandom_range(32'h4000, 32'h40000));
         if (p == 2) hold_armed = 1'b1;
         queue_random_tensors(115);
         wait_for_drain();
      end

      repeat (20) @(posedge clock);
      $display("checked %0d results (%0d scale sums) for %0d elements in %0d tensors",
               results_seen, sums_seen, elements_sent, tensors_queued);
      $display("%0d register settings, one %0d-cycle receiver hold-off, %0d mismatches",
               settings_used, HOLD_CYCLES, mismatches);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
sv/lsqfq_pkg.sv
sv/lsqfq_csr.sv
sv/lsqfq_ctrl.sv
sv/lsqfq_dp.sv
sv/lsq_fake_quant_grad.sv
bench/lsq_fake_quant_grad_test.sv
